FILE: src/e2c_pkg.sv
// e2c_pkg: shared types, constants and calendar helpers for the epoch to
// calendar converter. No dependencies; used by every module but the checker.

package e2c_pkg;

	// Queue between front and back
	localparam int unsigned E2C_QUEUE_DEPTH = 2;

	// Day count since the epoch fits 16 bits (at most 49710)
	localparam int unsigned DAYS_W = 16;

	// Calendar constants
	localparam logic [7:0] EPOCH_YEAR     = 8'd70;
	localparam logic [7:0] YEAR_2100      = 8'd200;
	localparam logic [8:0] DAYS_LEAP      = 9'd366;
	localparam logic [8:0] DAYS_COMMON    = 9'd365;
	localparam logic [4:0] FEB_LEAP       = 5'd29;
	localparam logic [4:0] FEB_COMMON     = 5'd28;
	localparam logic [6:0] SECS_PER_MIN   = 7'd60;
	localparam logic [6:0] MINS_PER_HOUR  = 7'd60;
	localparam logic [6:0] HOURS_PER_DAY  = 7'd24;
	localparam logic [6:0] DAYS_PER_WEEK  = 7'd7;
	localparam logic [2:0] EPOCH_WEEKDAY  = 3'd4;
	localparam logic [3:0] FEBRUARY       = 4'd1;
	localparam logic [3:0] LAST_MONTH     = 4'd11;

	// Time-of-day split plus day count, handed from front to back
	typedef struct packed {
		logic [5:0]        sec;
		logic [5:0]        min;
		logic [4:0]        hour;
		logic [DAYS_W-1:0] days;
		logic [2:0]        wday;
	} e2c_item_t;

	// Gregorian leap rule over years 1970..2155: only 2000 of the century
	// years is leap, 2100 is not
	function automatic logic is_leap(input logic [7:0] y1900);
		return (y1900[1:0] == 2'b00) && (y1900 != YEAR_2100);
	endfunction

	// Month length, February by leap flag
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			FEBRUARY: len = leap ? FEB_LEAP : FEB_COMMON;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: src/e2c_front.sv
// e2c_front: accepts epoch words and splits them into seconds, minutes,
// hours, day count and weekday with a shared reciprocal multiplier. Uses e2c_pkg.

module e2c_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                epoch_valid,
	output logic                epoch_stall,
	input  logic [31:0]         epoch_seconds,
	output logic                push,
	output e2c_pkg::e2c_item_t  push_item,
	input  logic                full
);
	import e2c_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	typedef enum logic [1:0] {
		PH_SEC,
		PH_MIN,
		PH_HOUR,
		PH_WDAY
	} div_phase_t;

	// Reciprocals: q = (n * RECIP) >> shift, exact over each phase's dividend range
	localparam logic [31:0] RECIP_60 = 32'h88888889;	// shift 37, any 32-bit n
	localparam logic [31:0] RECIP_24 = 32'hAAAAAAAB;	// shift 36, any 32-bit n
	localparam logic [31:0] RECIP_7  = 32'h92492493;	// shift 34, n below 2^31

	front_state_t state_q;
	div_phase_t   phase_q;
	logic         rem_step_q;
	logic [31:0]  work_q;
	logic [31:0]  quo_q;
	e2c_item_t    item_q;

	logic [31:0]  recip;
	logic [6:0]   divisor;
	logic [63:0]  prod;
	logic [31:0]  quo_d;
	logic [31:0]  rem_full;
	logic [5:0]   rem_d;

	// Reciprocal, divisor and product shift for the current phase
	always_comb begin
		unique case (phase_q)
			PH_SEC: begin
				recip   = RECIP_60;
				divisor = SECS_PER_MIN;
				quo_d   = 32'(prod[63:37]);
			end
			PH_MIN: begin
				recip   = RECIP_60;
				divisor = MINS_PER_HOUR;
				quo_d   = 32'(prod[63:37]);
			end
			PH_HOUR: begin
				recip   = RECIP_24;
				divisor = HOURS_PER_DAY;
				quo_d   = 32'(prod[63:36]);
			end
			PH_WDAY: begin
				recip   = RECIP_7;
				divisor = DAYS_PER_WEEK;
				quo_d   = 32'(prod[63:34]);
			end
		endcase
	end

	// Each phase first registers the quotient, then forms the remainder from it
	assign prod     = 64'(work_q) * 64'(recip);
	assign rem_full = work_q - quo_q * 32'(divisor);
	assign rem_d    = rem_full[5:0];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			phase_q    <= PH_SEC;
			rem_step_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (epoch_valid) begin
						state_q    <= F_DIV;
						phase_q    <= PH_SEC;
						rem_step_q <= 1'b0;
					end
				end
				F_DIV: begin
					rem_step_q <= !rem_step_q;
					if (rem_step_q) begin
						phase_q <= div_phase_t'(phase_q + 2'd1);
						if (phase_q == PH_WDAY) begin
							state_q <= F_PUSH;
						end
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Divider datapath and captured fields
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			work_q <= epoch_seconds;
		end else if (state_q == F_DIV) begin
			if (!rem_step_q) begin
				quo_q <= quo_d;
			end else begin
				unique case (phase_q)
					PH_SEC: begin
						item_q.sec <= rem_d;
						work_q     <= quo_q;
					end
					PH_MIN: begin
						item_q.min <= rem_d;
						work_q     <= quo_q;
					end
					PH_HOUR: begin
						item_q.hour <= rem_d[4:0];
						item_q.days <= quo_q[DAYS_W-1:0];
						work_q      <= quo_q + 32'(EPOCH_WEEKDAY);
					end
					PH_WDAY: begin
						item_q.wday <= rem_d[2:0];
					end
				endcase
			end
		end
	end

	assign epoch_stall = (state_q != F_IDLE);
	assign push        = (state_q == F_PUSH) && !full;
	assign push_item   = item_q;

endmodule

FILE: src/e2c_queue.sv
// e2c_queue: short FIFO of split words between front and back.
// Uses e2c_pkg for the word type and default depth.

module e2c_queue #(
	parameter int unsigned DEPTH = e2c_pkg::E2C_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  e2c_pkg::e2c_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output e2c_pkg::e2c_item_t  pop_item,
	output logic                empty
);
	import e2c_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	e2c_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item = mem_q[rd_ptr_q];
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

endmodule

FILE: src/e2c_back.sv
// e2c_back: steps a day count through years and months and presents the
// finished calendar word in an output register. Uses e2c_pkg.

module e2c_back (
	input  logic                clk,
	input  logic                arst_n,
	output logic                pop,
	input  e2c_pkg::e2c_item_t  pop_item,
	input  logic                empty,
	output logic                cal_valid,
	input  logic                cal_stall,
	output logic [5:0]          second_of_minute,
	output logic [5:0]          minute_of_hour,
	output logic [4:0]          hour_of_day,
	output logic [4:0]          day_of_month,
	output logic [3:0]          month_index,
	output logic [7:0]          years_since_1900,
	output logic [2:0]          week_day
);
	import e2c_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_YEAR  = 3'b010,
		B_MONTH = 3'b100
	} back_state_t;

	back_state_t       state_q;
	logic              cal_valid_q;
	e2c_item_t         hold_q;
	logic [DAYS_W-1:0] days_q;
	logic [7:0]        year_q;
	logic [3:0]        month_q;

	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [4:0]        mday_q;
	logic [3:0]        mon_q;
	logic [7:0]        yr_q;
	logic [2:0]        wday_q;

	logic              leap;
	logic [8:0]        year_len;
	logic [4:0]        mon_len;
	logic              year_fits;
	logic              month_done;
	logic              out_free;
	logic              emit;

	// Length of the current year and month
	assign leap       = is_leap(year_q);
	assign year_len   = leap ? DAYS_LEAP : DAYS_COMMON;
	assign mon_len    = month_len(month_q, leap);
	assign year_fits  = (days_q < DAYS_W'(year_len));
	// December takes whatever is left
	assign month_done = (days_q < DAYS_W'(mon_len)) || (month_q == LAST_MONTH);
	assign out_free   = !cal_valid_q || !cal_stall;
	assign emit       = (state_q == B_MONTH) && month_done && out_free;
	assign pop        = (state_q == B_IDLE) && !empty;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cal_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= B_YEAR;
					end
				end
				B_YEAR: begin
					if (year_fits) begin
						state_q <= B_MONTH;
					end
				end
				B_MONTH: begin
					if (emit) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (emit) begin
				cal_valid_q <= 1'b1;
			end else if (!cal_stall) begin
				cal_valid_q <= 1'b0;
			end
		end
	end

	// Year and month stepping
	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q  <= pop_item;
			days_q  <= pop_item.days;
			year_q  <= EPOCH_YEAR;
			month_q <= '0;
		end else if ((state_q == B_YEAR) && !year_fits) begin
			days_q <= days_q - DAYS_W'(year_len);
			year_q <= year_q + 8'd1;
		end else if ((state_q == B_MONTH) && !month_done) begin
			days_q  <= days_q - DAYS_W'(mon_len);
			month_q <= month_q + 4'd1;
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			sec_q  <= hold_q.sec;
			min_q  <= hold_q.min;
			hour_q <= hold_q.hour;
			mday_q <= days_q[4:0] + 5'd1;
			mon_q  <= month_q;
			yr_q   <= year_q;
			wday_q <= hold_q.wday;
		end
	end

	assign cal_valid        = cal_valid_q;
	assign second_of_minute = sec_q;
	assign minute_of_hour   = min_q;
	assign hour_of_day      = hour_q;
	assign day_of_month     = mday_q;
	assign month_index      = mon_q;
	assign years_since_1900 = yr_q;
	assign week_day         = wday_q;

endmodule

FILE: src/epoch_to_calendar_unit.sv
// epoch_to_calendar_unit: top level of the Unix seconds to UTC calendar converter.
// Depends on e2c_pkg, e2c_front, e2c_queue and e2c_back.

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, day of month, month (0 = January), year minus 1900
// and weekday (0 = Sunday), one output word per input word. The front
// splits off seconds, minutes, hours and weekday with one shared reciprocal
// multiplier, forming each quotient and then its remainder, and takes no new
// word until it has pushed the last one into the queue. The back walks the
// day count one year per cycle from 1970 and then one month per cycle. A
// small queue between them lets the front split the next word while the
// back is still stepping. The output word sits in a register, so a stall on
// the output side holds the back first and reaches the front only once the
// queue is full.

module epoch_to_calendar_unit #(
	parameter int unsigned QUEUE_DEPTH = e2c_pkg::E2C_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        epoch_valid,
	output logic        epoch_stall,
	input  logic [31:0] epoch_seconds,
	output logic        cal_valid,
	input  logic        cal_stall,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_index,
	output logic [7:0]  years_since_1900,
	output logic [2:0]  week_day
);
	import e2c_pkg::*;

	logic      push;
	logic      full;
	logic      pop;
	logic      empty;
	e2c_item_t push_item;
	e2c_item_t pop_item;

	// Front: time-of-day split
	e2c_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.epoch_valid   (epoch_valid),
		.epoch_stall   (epoch_stall),
		.epoch_seconds (epoch_seconds),
		.push          (push),
		.push_item     (push_item),
		.full          (full)
	);

	// Decoupling queue
	e2c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	// Back: date stepping and output register
	e2c_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop              (pop),
		.pop_item         (pop_item),
		.empty            (empty),
		.cal_valid        (cal_valid),
		.cal_stall        (cal_stall),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900),
		.week_day         (week_day)
	);

endmodule

FILE: src/e2c_checker.sv
// e2c_checker: port-level assertions for epoch_to_calendar_unit, attached
// by the bind at the end of this file. No package dependency.

module e2c_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       epoch_valid,
	input logic       epoch_stall,
	input logic       cal_valid,
	input logic       cal_stall,
	input logic [5:0] second_of_minute,
	input logic [5:0] minute_of_hour,
	input logic [4:0] hour_of_day,
	input logic [4:0] day_of_month,
	input logic [3:0] month_index,
	input logic [7:0] years_since_1900,
	input logic [2:0] week_day
);

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && cal_stall |=> cal_valid && $stable({second_of_minute, minute_of_hour,
			hour_of_day, day_of_month, month_index, years_since_1900, week_day}))
		else $error("output word changed while stalled");

	// Front is busy right after taking a word
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_valid && !epoch_stall |=> epoch_stall)
		else $error("front took a second word while dividing");

	// Time fields in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60) &&
			(hour_of_day < 5'd24) && (week_day < 3'd7))
		else $error("time field out of range");

	// Date fields in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (day_of_month != 5'd0) && (month_index < 4'd12) &&
			(years_since_1900 >= 8'd70) && (years_since_1900 <= 8'd206))
		else $error("date field out of range");

endmodule

bind epoch_to_calendar_unit e2c_checker u_e2c_checker (.*);
